/* src/ant_colony_tour_step_defines.svh */
`ifndef ANT_COLONY_TOUR_STEP_DEFINES_SVH
`define ANT_COLONY_TOUR_STEP_DEFINES_SVH

// Same-cycle implication check, gated by the active-low reset
`define ACTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acts check failed");

// Next-cycle implication check, gated by the active-low reset
`define ACTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acts check failed");

`endif

/* src/acts_pkg.sv */
package acts_pkg;

    localparam int MAX_CITIES = 128;
    localparam int CITY_W     = $clog2(MAX_CITIES);
    localparam int CNT_W      = $clog2(MAX_CITIES + 1);
    localparam int ADDR_W     = 2 * CITY_W;
    localparam int COST_W     = 16;
    localparam int TOT_W      = 23;
    localparam int PH_W       = 32;
    localparam int SQ_W       = 2 * PH_W;
    localparam int SUM_W      = SQ_W + CITY_W;
    localparam int RND_W      = 10;
    localparam int LHS_W      = SUM_W + RND_W;
    localparam int W1K_W      = SQ_W + RND_W;

    localparam logic [TOT_W-1:0] COST_MAX = {TOT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STEP  = 2'd1,
        OP_DEP   = 2'd2,
        OP_CLEAR = 2'd3
    } acts_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LD_DIV,
        ST_SCAN1,
        ST_LHS,
        ST_SCAN2,
        ST_PICK,
        ST_FIN,
        ST_DEP_CACC,
        ST_DEP_PUSH,
        ST_DEP_CLS_RD,
        ST_DEP_CLS_ACC,
        ST_DEP_TOT,
        ST_DEP_DIV,
        ST_WK_BUF,
        ST_WK_BWAIT,
        ST_WK_PRD,
        ST_WK_PWR,
        ST_DONE
    } acts_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic ld_write;
        logic div_start;
        logic div_sel_acc;
        logic ph_wr_recip;
        logic step_init;
        logic scan_clr;
        logic sum_clr;
        logic scan_issue;
        logic lhs_clr;
        logic lhs_step;
        logic pick;
        logic step_fin;
        logic nofree;
        logic cost_rd_edge;
        logic cost_rd_close;
        logic acc_add;
        logic buf_push;
        logic total_set;
        logic wk_clr;
        logic wk_buf_rd;
        logic wk_b_set;
        logic wk_ph_rd;
        logic wk_ph_wr;
        logic tour_reset;
        logic clear_best;
        logic status_bad;
        logic out_load;
    } acts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        acts_op_t op;
        logic     load_bad;
        logic     dep_bad;
        logic     tl_zero;
        logic     last;
        logic     any_free;
        logic     scan_end;
        logic     pipe_busy;
        logic     lhs_done;
        logic     div_done;
        logic     wk_last;
        logic     out_free;
    } acts_stat_t;

endpackage

/* src/acts_recip.sv */
// Serial reciprocal: floor(2^32 / divisor), saturated to 32 bits, one quotient bit a cycle
module acts_recip (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [acts_pkg::TOT_W-1:0] divisor,
    output logic                      done,
    output logic [acts_pkg::PH_W-1:0]  quotient
);
    import acts_pkg::*;

    localparam int QB    = PH_W + 1;
    localparam int QCW   = $clog2(QB + 1);

    logic [TOT_W-1:0] div_reg;
    logic [TOT_W:0]   rem_reg, rem_next;
    logic [QB-1:0]    q_reg, q_next;
    logic [QCW-1:0]   cnt_reg;
    logic             busy_reg, done_reg;
    logic [TOT_W:0]   shifted;
    logic             dbit;

    // dividend is a one followed by PH_W zeros
    always_comb begin
        dbit     = (cnt_reg == '0);
        shifted  = {rem_reg[TOT_W-1:0], dbit};
        rem_next = shifted;
        q_next   = {q_reg[QB-2:0], 1'b0};
        if (shifted >= {1'b0, div_reg}) begin
            rem_next = shifted - {1'b0, div_reg};
            q_next   = {q_reg[QB-2:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                div_reg  <= divisor;
                rem_reg  <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QCW'(QB - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    // zero divisor and quotient 2^32 both saturate
    assign quotient = (q_reg[QB-1] || div_reg == '0) ? {PH_W{1'b1}} : q_reg[PH_W-1:0];

endmodule

/* src/acts_datapath.sv */
// Tables, tour state, roulette pipeline and result registers
module acts_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  acts_pkg::acts_cmd_t        cmd,
    output acts_pkg::acts_stat_t       stat,
    input  logic                       cfg_wr_en,
    input  logic [7:0]                 cfg_wr_data,
    input  logic [1:0]                 s_opcode,
    input  logic [6:0]                 s_row_city,
    input  logic [6:0]                 s_col_city,
    input  logic [15:0]                s_edge_cost,
    input  logic [9:0]                 s_random_value,
    input  logic [6:0]                 s_tour_city,
    input  logic                       s_tour_last,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [6:0]                 m_chosen_city,
    output logic                       m_tour_complete,
    output logic [22:0]                m_tour_cost,
    output logic                       m_new_best,
    output logic [22:0]                m_best_cost,
    output logic                       m_status
);
    import acts_pkg::*;

    localparam int LCW = $clog2(RND_W + 1);

    // memories
    logic [COST_W-1:0] cost_mem [0:(1<<ADDR_W)-1];
    logic [PH_W-1:0]   ph_mem   [0:(1<<ADDR_W)-1];
    logic [CITY_W-1:0] buf_mem  [0:MAX_CITIES-1];
    logic [COST_W-1:0] cost_q_reg;
    logic [PH_W-1:0]   ph_q_reg;
    logic [CITY_W-1:0] buf_q_reg;

    // request registers
    acts_op_t          op_reg;
    logic [CITY_W-1:0] row_reg, col_reg, city_reg;
    logic [COST_W-1:0] cost_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic              last_reg;

    logic [7:0]        cities_reg;
    logic [CNT_W-1:0]  n_act;
    logic [MAX_CITIES-1:0] nmask;

    // tour construction state
    logic [MAX_CITIES-1:0] visited_reg;
    logic [CITY_W-1:0] cur_reg, steps_reg;

    // roulette pipeline
    logic [CNT_W-1:0]  j_reg;
    logic              pass2_reg;
    logic              p1_v, p2_v, p3_v, p4_v;
    logic              p1_f, p2_f, p3_f, p4_f;
    logic [CITY_W-1:0] p1_j, p2_j, p3_j, p4_j;
    logic [SQ_W-1:0]   sq_reg;
    logic [W1K_W-1:0]  w1k_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [LHS_W-1:0]  cum_reg, lhs_reg;
    logic [RND_W-1:0]  rnd_sh_reg;
    logic [LCW-1:0]    lcnt_reg;
    logic              found_reg;
    logic [CITY_W-1:0] found_j_reg, lastfree_reg, pick_city;

    // deposit state
    logic [CNT_W-1:0]  tl_reg, k_reg, k_inc;
    logic [CITY_W-1:0] prev_reg, first_reg, a_reg, b_reg;
    logic [TOT_W-1:0]  acc_reg, best_reg;
    logic [TOT_W:0]    acc_sum;
    logic [PH_W:0]     dep_sum;

    // result registers
    logic [CITY_W-1:0] res_chosen;
    logic              res_complete, res_better, res_status;
    logic [TOT_W-1:0]  res_total;
    logic              m_valid_reg;

    // divider
    logic              div_done;
    logic [PH_W-1:0]   div_q;
    logic [TOT_W-1:0]  div_in;

    logic              ph_rd_en, cost_rd_en, ph_wr_en;
    logic [ADDR_W-1:0] ph_raddr, cost_raddr, ph_waddr;
    logic [PH_W-1:0]   ph_wdata;

    assign div_in = cmd.div_sel_acc ? acc_reg : TOT_W'(cost_reg);

    acts_recip u_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .divisor  (div_in),
        .done     (div_done),
        .quotient (div_q)
    );

    // active city count, clamped to 2..MAX_CITIES
    always_comb begin
        if (cities_reg < 8'd2) begin
            n_act = CNT_W'(2);
        end else if (CNT_W'(cities_reg) > CNT_W'(MAX_CITIES)) begin
            n_act = CNT_W'(MAX_CITIES);
        end else begin
            n_act = CNT_W'(cities_reg);
        end
        for (int i = 0; i < MAX_CITIES; i++) begin
            nmask[i] = (CNT_W'(i) < n_act);
        end
    end

    assign k_inc   = k_reg + 1'b1;
    assign acc_sum = {1'b0, acc_reg} + (TOT_W+1)'(cost_q_reg);
    assign dep_sum = {1'b0, ph_q_reg} + {1'b0, div_q};
    assign pick_city = found_reg ? found_j_reg : lastfree_reg;

    // memory address and enable selection
    always_comb begin
        ph_rd_en   = cmd.scan_issue | cmd.wk_ph_rd;
        ph_raddr   = cmd.scan_issue ? {cur_reg, j_reg[CITY_W-1:0]} : {a_reg, b_reg};
        cost_rd_en = cmd.cost_rd_edge | cmd.cost_rd_close;
        cost_raddr = cmd.cost_rd_edge ? {prev_reg, city_reg} : {city_reg, first_reg};
        ph_wr_en   = cmd.ph_wr_recip | cmd.wk_ph_wr;
        ph_waddr   = cmd.ph_wr_recip ? {row_reg, col_reg} : {a_reg, b_reg};
        if (cmd.ph_wr_recip) begin
            ph_wdata = div_q;
        end else begin
            ph_wdata = dep_sum[PH_W] ? {PH_W{1'b1}} : dep_sum[PH_W-1:0];
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.ld_write) begin
            cost_mem[{row_reg, col_reg}] <= cost_reg;
        end
        if (cost_rd_en) begin
            cost_q_reg <= cost_mem[cost_raddr];
        end
        if (ph_wr_en) begin
            ph_mem[ph_waddr] <= ph_wdata;
        end
        if (ph_rd_en) begin
            ph_q_reg <= ph_mem[ph_raddr];
        end
        if (cmd.buf_push) begin
            buf_mem[tl_reg[CITY_W-1:0]] <= city_reg;
        end
        if (cmd.wk_buf_rd) begin
            buf_q_reg <= buf_mem[k_inc[CITY_W-1:0]];
        end
    end

    // request capture and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cities_reg <= 8'd64;
        end else if (cfg_wr_en) begin
            cities_reg <= cfg_wr_data;
        end
        if (cmd.capture) begin
            op_reg   <= acts_op_t'(s_opcode);
            row_reg  <= s_row_city;
            col_reg  <= s_col_city;
            cost_reg <= s_edge_cost;
            rnd_reg  <= s_random_value;
            city_reg <= s_tour_city;
            last_reg <= s_tour_last;
        end
    end

    // roulette pipeline: read, square, scale by 1000, accumulate and compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v <= 1'b0;
            p2_v <= 1'b0;
            p3_v <= 1'b0;
            p4_v <= 1'b0;
        end else begin
            p1_v <= cmd.scan_issue;
            p2_v <= p1_v;
            p3_v <= p2_v & pass2_reg;
            p4_v <= p3_v;
        end
        p1_j <= j_reg[CITY_W-1:0];
        p1_f <= ~visited_reg[j_reg[CITY_W-1:0]];
        p2_j <= p1_j;
        p2_f <= p1_f;
        p3_j <= p2_j;
        p3_f <= p2_f;
        p4_j <= p3_j;
        p4_f <= p3_f;
        sq_reg  <= p1_f ? SQ_W'(ph_q_reg * ph_q_reg) : '0;
        w1k_reg <= (W1K_W'(sq_reg) << 10) - (W1K_W'(sq_reg) << 4) - (W1K_W'(sq_reg) << 3);

        if (cmd.scan_clr) begin
            j_reg     <= '0;
            cum_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.scan_issue) begin
                j_reg <= j_reg + 1'b1;
            end
            if (p3_v) begin
                cum_reg <= cum_reg + LHS_W'(w1k_reg);
            end
            if (p4_v && p4_f && !found_reg && lhs_reg < cum_reg) begin
                found_reg   <= 1'b1;
                found_j_reg <= p4_j;
            end
        end

        if (cmd.sum_clr) begin
            sum_reg      <= '0;
            lastfree_reg <= '0;
            pass2_reg    <= 1'b0;
        end else begin
            if (p1_v && p1_f && !pass2_reg) begin
                lastfree_reg <= p1_j;
            end
            if (p2_v && !pass2_reg) begin
                sum_reg <= sum_reg + SUM_W'(sq_reg);
            end
            if (cmd.lhs_clr) begin
                pass2_reg <= 1'b1;
            end
        end

        // draw times sum, one multiplier bit a cycle
        if (cmd.lhs_clr) begin
            lhs_reg    <= '0;
            rnd_sh_reg <= rnd_reg;
            lcnt_reg   <= '0;
        end else if (cmd.lhs_step) begin
            lhs_reg    <= (lhs_reg << 1) + (rnd_sh_reg[RND_W-1] ? LHS_W'(sum_reg) : '0);
            rnd_sh_reg <= rnd_sh_reg << 1;
            lcnt_reg   <= lcnt_reg + 1'b1;
        end
    end

    // tour, deposit and best-cost state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
            cur_reg     <= '0;
            steps_reg   <= '0;
            tl_reg      <= '0;
            acc_reg     <= '0;
            best_reg    <= COST_MAX;
        end else begin
            // tour start: only city 0 visited
            if (cmd.step_init && steps_reg == '0) begin
                visited_reg <= MAX_CITIES'(1);
                cur_reg     <= '0;
            end
            if (cmd.pick) begin
                visited_reg[pick_city] <= 1'b1;
                cur_reg                <= pick_city;
                steps_reg              <= steps_reg + 1'b1;
            end
            if ((cmd.step_fin && !stat.any_free) || cmd.nofree) begin
                steps_reg <= '0;
            end
            if (cmd.acc_add) begin
                acc_reg <= acc_sum[TOT_W] ? COST_MAX : acc_sum[TOT_W-1:0];
            end
            if (cmd.buf_push) begin
                tl_reg <= tl_reg + 1'b1;
            end
            if (cmd.total_set && acc_reg < best_reg) begin
                best_reg <= acc_reg;
            end
            if (cmd.tour_reset) begin
                tl_reg  <= '0;
                acc_reg <= '0;
            end
            if (cmd.clear_best) begin
                best_reg <= COST_MAX;
            end
        end
        if (cmd.buf_push) begin
            prev_reg <= city_reg;
            if (tl_reg == '0) begin
                first_reg <= city_reg;
            end
        end
        // edge walk over the buffered tour
        if (cmd.wk_clr) begin
            k_reg <= '0;
            a_reg <= first_reg;
        end else if (cmd.wk_b_set) begin
            b_reg <= (k_inc < tl_reg) ? buf_q_reg : first_reg;
        end else if (cmd.wk_ph_wr) begin
            a_reg <= b_reg;
            k_reg <= k_inc;
        end
    end

    // result assembly
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_chosen   <= '0;
            res_complete <= 1'b0;
            res_total    <= '0;
            res_better   <= 1'b0;
            res_status   <= 1'b0;
        end else begin
            if (cmd.pick) begin
                res_chosen <= pick_city;
            end
            if ((cmd.step_fin && !stat.any_free) || cmd.nofree) begin
                res_complete <= 1'b1;
            end
            if (cmd.nofree || cmd.status_bad) begin
                res_status <= 1'b1;
            end
            if (cmd.total_set) begin
                res_total  <= acc_reg;
                res_better <= (acc_reg < best_reg);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_chosen_city   <= res_chosen;
            m_tour_complete <= res_complete;
            m_tour_cost     <= res_total;
            m_new_best      <= res_better;
            m_best_cost     <= best_reg;
            m_status        <= res_status;
        end
    end

    assign m_valid = m_valid_reg;

    // status to controller
    always_comb begin
        stat.op        = op_reg;
        stat.load_bad  = (CNT_W'(row_reg) >= n_act) || (CNT_W'(col_reg) >= n_act);
        stat.dep_bad   = (CNT_W'(city_reg) >= n_act) || (tl_reg >= n_act);
        stat.tl_zero   = (tl_reg == '0);
        stat.last      = last_reg;
        stat.any_free  = |(~visited_reg & nmask);
        stat.scan_end  = (j_reg == n_act);
        stat.pipe_busy = p1_v | p2_v | p3_v | p4_v;
        stat.lhs_done  = (lcnt_reg == LCW'(RND_W));
        stat.div_done  = div_done;
        stat.wk_last   = (k_inc == tl_reg);
        stat.out_free  = ~m_valid_reg | m_ready;
    end

endmodule

/* src/acts_ctrl.sv */
// Sequencer for load, construct step, deposit and clear requests
module acts_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  acts_pkg::acts_stat_t stat,
    output acts_pkg::acts_cmd_t  cmd
);
    import acts_pkg::*;

    acts_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.op)
                    OP_LOAD: begin
                        if (stat.load_bad) begin
                            cmd.status_bad = 1'b1;
                            state_next     = ST_DONE;
                        end else begin
                            cmd.ld_write  = 1'b1;
                            cmd.div_start = 1'b1;
                            state_next    = ST_LD_DIV;
                        end
                    end
                    OP_STEP: begin
                        cmd.step_init = 1'b1;
                        cmd.scan_clr  = 1'b1;
                        cmd.sum_clr   = 1'b1;
                        state_next    = ST_SCAN1;
                    end
                    OP_DEP: begin
                        if (stat.dep_bad) begin
                            cmd.status_bad = 1'b1;
                            state_next     = ST_DONE;
                        end else if (!stat.tl_zero) begin
                            cmd.cost_rd_edge = 1'b1;
                            state_next       = ST_DEP_CACC;
                        end else begin
                            state_next = ST_DEP_PUSH;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.clear_best = 1'b1;
                        state_next     = ST_DONE;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_LD_DIV: begin
                if (stat.div_done) begin
                    cmd.ph_wr_recip = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            // first pass: sum of weights and last free city
            ST_SCAN1: begin
                if (!stat.scan_end) begin
                    cmd.scan_issue = 1'b1;
                end else if (!stat.pipe_busy) begin
                    if (!stat.any_free) begin
                        cmd.nofree = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        cmd.lhs_clr = 1'b1;
                        state_next  = ST_LHS;
                    end
                end
            end
            ST_LHS: begin
                if (!stat.lhs_done) begin
                    cmd.lhs_step = 1'b1;
                end else begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN2;
                end
            end
            // second pass: cumulative pick
            ST_SCAN2: begin
                if (!stat.scan_end) begin
                    cmd.scan_issue = 1'b1;
                end else if (!stat.pipe_busy) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                cmd.pick   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.step_fin = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DEP_CACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DEP_PUSH;
            end
            ST_DEP_PUSH: begin
                cmd.buf_push = 1'b1;
                state_next   = stat.last ? ST_DEP_CLS_RD : ST_DONE;
            end
            ST_DEP_CLS_RD: begin
                cmd.cost_rd_close = 1'b1;
                state_next        = ST_DEP_CLS_ACC;
            end
            ST_DEP_CLS_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DEP_TOT;
            end
            ST_DEP_TOT: begin
                cmd.total_set   = 1'b1;
                cmd.div_start   = 1'b1;
                cmd.div_sel_acc = 1'b1;
                state_next      = ST_DEP_DIV;
            end
            ST_DEP_DIV: begin
                if (stat.div_done) begin
                    cmd.wk_clr = 1'b1;
                    state_next = ST_WK_BUF;
                end
            end
            // per edge: fetch next city, read pheromone, write deposit
            ST_WK_BUF: begin
                cmd.wk_buf_rd = 1'b1;
                state_next    = ST_WK_BWAIT;
            end
            ST_WK_BWAIT: begin
                cmd.wk_b_set = 1'b1;
                state_next   = ST_WK_PRD;
            end
            ST_WK_PRD: begin
                cmd.wk_ph_rd = 1'b1;
                state_next   = ST_WK_PWR;
            end
            ST_WK_PWR: begin
                cmd.wk_ph_wr = 1'b1;
                if (stat.wk_last) begin
                    cmd.tour_reset = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    state_next = ST_WK_BUF;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* src/ant_colony_tour_step.sv */
// Ant-colony tour engine, one request at a time. A load (opcode 0) is paced by the
// 33-step serial reciprocal. A construct step (opcode 1) for n active cities makes two
// pipelined scans of the pheromone row, one city a cycle through the single read port,
// and a serial multiply of the draw. On the last city of a tour, a deposit adds the
// reciprocal and a read-modify-write of the pheromone memory for each tour edge.
// A new request is taken while the previous result waits.
// Cost and pheromone entries must be written before a step or deposit reads them.
module ant_colony_tour_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [6:0]  s_row_city,
    input  logic [6:0]  s_col_city,
    input  logic [15:0] s_edge_cost,
    input  logic [9:0]  s_random_value,
    input  logic [6:0]  s_tour_city,
    input  logic        s_tour_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_chosen_city,
    output logic        m_tour_complete,
    output logic [22:0] m_tour_cost,
    output logic        m_new_best,
    output logic [22:0] m_best_cost,
    output logic        m_status
);
    import acts_pkg::*;

    acts_cmd_t  cmd;
    acts_stat_t stat;

    acts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    acts_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_opcode        (s_opcode),
        .s_row_city      (s_row_city),
        .s_col_city      (s_col_city),
        .s_edge_cost     (s_edge_cost),
        .s_random_value  (s_random_value),
        .s_tour_city     (s_tour_city),
        .s_tour_last     (s_tour_last),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_chosen_city   (m_chosen_city),
        .m_tour_complete (m_tour_complete),
        .m_tour_cost     (m_tour_cost),
        .m_new_best      (m_new_best),
        .m_best_cost     (m_best_cost),
        .m_status        (m_status)
    );

endmodule

/* src/acts_checker.sv */
`include "ant_colony_tour_step_defines.svh"

// Port-level checks on the tour engine
module acts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [6:0]  m_chosen_city,
    input logic        m_tour_complete,
    input logic [22:0] m_tour_cost,
    input logic        m_new_best,
    input logic [22:0] m_best_cost,
    input logic        m_status
);

    // a stalled result holds
    `ACTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_best_cost))
    // one request in flight: busy right after acceptance
    `ACTS_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a new best equals the tour total just reported
    `ACTS_ASSERT_NOW(a_best_match, aclk, aresetn, m_valid && m_new_best, m_best_cost == m_tour_cost)
    // an error result carries no tour total and no new best
    `ACTS_ASSERT_NOW(a_err_clean, aclk, aresetn, m_valid && m_status, !m_new_best && m_tour_cost == 23'd0)

endmodule

bind ant_colony_tour_step acts_checker u_acts_checker (.*);
